// ----- hw/rtl/bfsa_pkg.sv -----
package bfsa_pkg;

  localparam int unsigned MaxSegments = 32;
  localparam int unsigned TotalSpace  = 256;
  localparam int unsigned IdxW        = $clog2(MaxSegments);
  localparam int unsigned CntW        = IdxW + 1;
  localparam int unsigned SizeW       = 9;
  localparam int unsigned IdW         = 16;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_FIT = 2'd1,
    ST_NO_ID  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef struct packed {
    logic             kind;
    logic [SizeW-1:0] request_size;
    logic [IdW-1:0]   owner_id;
  } req_t;

  typedef struct packed {
    logic [1:0]     status;
    logic [IdW-1:0] granted_id;
  } res_t;

  typedef struct packed {
    logic             used;
    logic [IdW-1:0]   owner;
    logic [SizeW-1:0] size;
  } seg_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RD, S_EV, S_RDN, S_EVN, S_MRG, S_MVR, S_MVW, S_WRF, S_WRU
  } state_e;

endpackage

// ----- hw/rtl/best_fit_segment_allocator.sv -----
// Best-fit segment allocator with coalescing.
// Pulse start_i with req_i while busy_o is low to issue a request: kind
// allocate picks the smallest free segment that fits (lowest index on ties),
// kind free releases the segment owned by owner_id and merges free neighbors.
// One result per request appears on res_o for exactly one cycle with done_o
// high; the receiver cannot stall it and busy_o stays high until then.
// The segment table sits in a synchronous RAM with separate read and write addresses and a registered read.
// Steps: a scan reads and evaluates table entries in turn; each moved entry
// is read and written back one slot away. Allocate scans all N segments,
// shifts the entries from the best one upward, then writes the remainder
// and the used segment; free scans up to the owner, reads its right
// neighbor if any, writes the merged segment and shifts later entries down.
// After reset the init state writes the initial free segment to entry 0; busy_o
// is high during it. Entries beyond the segment count are never read, so the
// rest of the RAM needs no clearing.
module best_fit_segment_allocator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  bfsa_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output bfsa_pkg::res_t res_o
);
  import bfsa_pkg::*;

  // segment table
  seg_t mem_q [MaxSegments];
  seg_t rdata_q;
  logic we;
  logic [IdxW-1:0] waddr, raddr;
  seg_t wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d, idx_q, idx_d;
  logic [CntW-1:0] src_q, src_d, dst_q, dst_d, left_q, left_d;
  logic [IdxW-1:0] best_q, best_d;
  logic [SizeW-1:0] bsize_q, bsize_d;
  logic found_q, found_d, nfree_q, nfree_d, up_q, up_d;
  logic [IdW-1:0] next_id_q, next_id_d;
  req_t rq_q, rq_d;
  seg_t prev_q, prev_d, cur_q, cur_d, nxt_q, nxt_d;
  logic done_q, done_d;
  res_t res_q, res_d;

  // merge decode
  logic pfree;
  logic [CntW-1:0] mk, ms;
  logic [SizeW-1:0] msize;
  logic last;

  always_comb begin
    pfree = (best_q != '0) && !prev_q.used;
    mk    = CntW'(nfree_q) + CntW'(pfree);
    ms    = (pfree || !nfree_q) ? {1'b0, best_q} : {1'b0, best_q} + CntW'(1);
    msize = cur_q.size + (nfree_q ? nxt_q.size : '0) + (pfree ? prev_q.size : '0);
    last  = (idx_q + CntW'(1)) == count_q;
  end

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    unique case (state_q)
      S_INIT: begin
        we         = 1'b1;
        wdata.size = SizeW'(TotalSpace);
      end
      S_RD:  raddr = idx_q[IdxW-1:0];
      S_RDN: raddr = best_q + IdxW'(1);
      S_MVR: raddr = src_q[IdxW-1:0];
      S_MVW: begin
        we    = 1'b1;
        waddr = dst_q[IdxW-1:0];
        wdata = rdata_q;
      end
      S_WRF: begin
        we         = 1'b1;
        waddr      = best_q + IdxW'(1);
        wdata.size = bsize_q - rq_q.request_size;
      end
      S_WRU: begin
        we    = 1'b1;
        waddr = best_q;
        wdata = '{used: 1'b1, owner: next_id_q, size: rq_q.request_size};
      end
      S_MRG: begin
        we          = 1'b1;
        waddr       = pfree ? best_q - IdxW'(1) : best_q;
        wdata.owner = cur_q.owner;
        wdata.size  = msize;
      end
      default: ;
    endcase
  end

  // next state and datapath
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    src_d     = src_q;
    dst_d     = dst_q;
    left_d    = left_q;
    best_d    = best_q;
    bsize_d   = bsize_q;
    found_d   = found_q;
    nfree_d   = nfree_q;
    up_d      = up_q;
    next_id_d = next_id_q;
    rq_d      = rq_q;
    prev_d    = prev_q;
    cur_d     = cur_q;
    nxt_d     = nxt_q;
    done_d    = 1'b0;
    res_d     = res_q;
    unique case (state_q)
      S_INIT: state_d = S_IDLE;
      S_IDLE: begin
        if (start_i) begin
          rq_d    = req_i;
          idx_d   = '0;
          found_d = 1'b0;
          nfree_d = 1'b0;
          state_d = S_RD;
        end
      end
      S_RD: state_d = S_EV;
      S_EV: begin
        if (rq_q.kind == KIND_ALLOC) begin
          if (!rdata_q.used && rdata_q.size >= rq_q.request_size &&
              (!found_q || rdata_q.size < bsize_q)) begin
            found_d = 1'b1;
            best_d  = idx_q[IdxW-1:0];
            bsize_d = rdata_q.size;
          end
          idx_d   = idx_q + CntW'(1);
          state_d = S_RD;
          if (last) begin
            if (!found_d) begin
              res_d   = '{status: ST_NO_FIT, granted_id: '0};
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else if (count_q == CntW'(MaxSegments)) begin
              res_d   = '{status: ST_FULL, granted_id: '0};
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              up_d    = 1'b1;
              src_d   = count_q - CntW'(1);
              dst_d   = count_q;
              left_d  = count_q - {1'b0, best_d};
              state_d = S_MVR;
            end
          end
        end else begin
          if (rdata_q.used && rdata_q.owner == rq_q.owner_id) begin
            best_d  = idx_q[IdxW-1:0];
            cur_d   = rdata_q;
            state_d = last ? S_MRG : S_RDN;
          end else begin
            prev_d  = rdata_q;
            idx_d   = idx_q + CntW'(1);
            state_d = S_RD;
            if (last) begin
              res_d   = '{status: ST_NO_ID, granted_id: '0};
              done_d  = 1'b1;
              state_d = S_IDLE;
            end
          end
        end
      end
      S_RDN: state_d = S_EVN;
      S_EVN: begin
        nxt_d   = rdata_q;
        nfree_d = !rdata_q.used;
        state_d = S_MRG;
      end
      S_MRG: begin
        up_d    = 1'b0;
        src_d   = ms + mk;
        dst_d   = ms;
        left_d  = count_q - ms - mk;
        count_d = count_q - mk;
        if (mk == '0 || (count_q - ms - mk) == '0) begin
          res_d   = '{status: ST_OK, granted_id: '0};
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_MVR;
        end
      end
      S_MVR: state_d = S_MVW;
      S_MVW: begin
        left_d  = left_q - CntW'(1);
        src_d   = up_q ? src_q - CntW'(1) : src_q + CntW'(1);
        dst_d   = up_q ? dst_q - CntW'(1) : dst_q + CntW'(1);
        state_d = S_MVR;
        if (left_q == CntW'(1)) begin
          if (up_q) begin
            state_d = S_WRF;
          end else begin
            res_d   = '{status: ST_OK, granted_id: '0};
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_WRF: state_d = S_WRU;
      S_WRU: begin
        count_d   = count_q + CntW'(1);
        next_id_d = next_id_q + IdW'(1);
        res_d     = '{status: ST_OK, granted_id: next_id_q};
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      count_q   <= CntW'(1);
      next_id_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      next_id_q <= next_id_d;
      done_q    <= done_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    src_q   <= src_d;
    dst_q   <= dst_d;
    left_q  <= left_d;
    best_q  <= best_d;
    bsize_q <= bsize_d;
    found_q <= found_d;
    nfree_q <= nfree_d;
    up_q    <= up_d;
    rq_q    <= rq_d;
    prev_q  <= prev_d;
    cur_q   <= cur_d;
    nxt_q   <= nxt_d;
    res_q   <= res_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ----- test/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bfsa_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic done_o;
  res_t res_o;

  best_fit_segment_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // Shadow copy of the segment table
  logic [SizeW-1:0] seg_size[MaxSegments];
  logic             seg_used[MaxSegments];
  logic [IdW-1:0]   seg_owner[MaxSegments];
  int unsigned      seg_count;
  logic [IdW-1:0]   id_next;

  req_t pending_reqs[$];
  res_t expected_res[$];
  // Ids currently held by used segments, for building valid frees
  logic [IdW-1:0] live_ids[$];

  int unsigned mismatches;
  int unsigned idle_cycles;
  bit          timed_out;
  bit          fill_done;
  int          gap_left;
  int          burst_left;
  bit          hold_off;
  bit          in_acc;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void table_reset();
    for (int i = 0; i < MaxSegments; i++) begin
      seg_size[i] = '0;
      seg_used[i] = 1'b0;
      seg_owner[i] = '0;
    end
    seg_size[0] = SizeW'(TotalSpace);
    seg_count = 1;
    id_next = '0;
  endfunction

  function automatic void remove_seg(int unsigned pos);
    for (int unsigned i = pos; i + 1 < seg_count; i++) begin
      seg_size[i] = seg_size[i+1];
      seg_used[i] = seg_used[i+1];
      seg_owner[i] = seg_owner[i+1];
    end
    seg_count--;
  endfunction

  // Apply one request to the shadow table and return its result
  function automatic res_t allocate_or_free(req_t r);
    res_t res;
    int   best;
    int   pos;
    res = '0;
    best = -1;
    pos = -1;
    if (r.kind == KIND_ALLOC) begin
      for (int i = 0; i < seg_count; i++)
        if (!seg_used[i] && seg_size[i] >= r.request_size)
          if (best < 0 || seg_size[i] < seg_size[best]) best = i;
      if (best < 0) res.status = ST_NO_FIT;
      else if (seg_count >= MaxSegments) res.status = ST_FULL;
      else begin
        for (int i = seg_count; i > best; i--) begin
          seg_size[i] = seg_size[i-1];
          seg_used[i] = seg_used[i-1];
          seg_owner[i] = seg_owner[i-1];
        end
        seg_size[best] = r.request_size;
        seg_used[best] = 1'b1;
        seg_owner[best] = id_next;
        seg_size[best+1] = seg_size[best+1] - r.request_size;
        seg_count++;
        res.status = ST_OK;
        res.granted_id = id_next;
        live_ids.push_back(id_next);
        id_next = id_next + 1'b1;
      end
    end else begin
      for (int i = 0; i < seg_count; i++)
        if (seg_used[i] && seg_owner[i] == r.owner_id) begin
          pos = i;
          break;
        end
      if (pos < 0) res.status = ST_NO_ID;
      else begin
        res.status = ST_OK;
        foreach (live_ids[k])
          if (live_ids[k] == r.owner_id) begin
            live_ids.delete(k);
            break;
          end
        seg_used[pos] = 1'b0;
        if (pos + 1 < seg_count && !seg_used[pos+1]) begin
          seg_size[pos] = seg_size[pos] + seg_size[pos+1];
          remove_seg(pos + 1);
        end
        if (pos > 0 && !seg_used[pos-1]) begin
          seg_size[pos-1] = seg_size[pos-1] + seg_size[pos];
          remove_seg(pos);
        end
      end
    end
    return res;
  endfunction

  function automatic req_t make_req(logic kind, logic [SizeW-1:0] size, logic [IdW-1:0] id);
    req_t r;
    r.kind = kind;
    r.request_size = size;
    r.owner_id = id;
    return r;
  endfunction

  // Pick a free: mostly a live id, sometimes a random one
  function automatic req_t random_free();
    logic [IdW-1:0] id;
    id = IdW'($urandom);
    if (live_ids.size() > 0 && $urandom_range(0, 9) < 8)
      id = live_ids[$urandom_range(0, live_ids.size() - 1)];
    return make_req(KIND_FREE, SizeW'($urandom), id);
  endfunction

  function automatic logic [SizeW-1:0] random_size();
    case ($urandom_range(0, 9))
      0: return SizeW'($urandom);
      1: return '0;
      2, 3: return SizeW'($urandom_range(1, 64));
      default: return SizeW'($urandom_range(1, 16));
    endcase
  endfunction

  // Fill the request queue: directed corners, then random traffic
  initial begin
    fill_done = 1'b0;
    table_reset();
    pending_reqs.push_back(make_req(KIND_FREE, 9'd0, 16'd0));
    pending_reqs.push_back(make_req(KIND_ALLOC, 9'd257, 16'hffff));
    pending_reqs.push_back(make_req(KIND_ALLOC, 9'h1ff, 16'd0));
    pending_reqs.push_back(make_req(KIND_ALLOC, 9'd0, 16'd0));
    pending_reqs.push_back(make_req(KIND_ALLOC, 9'd10, 16'hffff));
    pending_reqs.push_back(make_req(KIND_ALLOC, 9'd20, 16'd0));
    pending_reqs.push_back(make_req(KIND_FREE, 9'h1ff, 16'd1));
    pending_reqs.push_back(make_req(KIND_ALLOC, 9'd5, 16'd0));
    pending_reqs.push_back(make_req(KIND_FREE, 9'd0, 16'hffff));
    pending_reqs.push_back(make_req(KIND_FREE, 9'd0, 16'd2));
    pending_reqs.push_back(make_req(KIND_FREE, 9'd0, 16'd0));
    pending_reqs.push_back(make_req(KIND_FREE, 9'd0, 16'd3));
    pending_reqs.push_back(make_req(KIND_ALLOC, 9'd256, 16'd0));
    pending_reqs.push_back(make_req(KIND_ALLOC, 9'd1, 16'd0));
    pending_reqs.push_back(make_req(KIND_FREE, 9'd0, 16'd4));
    // Fill the table with tiny segments to reach the full status
    for (int i = 0; i < 34; i++)
      pending_reqs.push_back(make_req(KIND_ALLOC, 9'd1, IdW'($urandom)));
    pending_reqs.push_back(make_req(KIND_ALLOC, 9'd300, 16'd0));
    for (int i = 0; i < 1700; i++) begin
      if ($urandom_range(0, 1)) pending_reqs.push_back(make_req(KIND_ALLOC, random_size(),
                                                               IdW'($urandom)));
      else pending_reqs.push_back(make_req(KIND_FREE, '0, '0));
    end
    fill_done = 1'b1;
  end

  // Driver: bursts and gaps, one hold-off until all results are in
  int unsigned sent;
  initial begin
    start_i = 1'b0;
    req_i = '0;
    rst_ni = 1'b0;
    sent = 0;
    gap_left = 0;
    burst_left = 0;
    hold_off = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Note whether the last rising edge took a request
  always @(posedge clk_i) begin
    in_acc <= start_i && !busy_o;
  end

  always @(negedge clk_i) begin
    if (rst_ni && fill_done) begin
      if (start_i) begin
        if (in_acc) start_i <= 1'b0;
      end else begin
        if (sent == 700 && !hold_off) begin
          if (expected_res.size() == 0) hold_off <= 1'b1;
        end else if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_reqs.size() > 0) begin
          req_t r;
          r = pending_reqs.pop_front();
          // Random frees are resolved now against current live ids
          if (r.kind == KIND_FREE && r.owner_id == 0 && r.request_size == 0 && sent >= 15)
            r = random_free();
          req_i <= r;
          start_i <= 1'b1;
          sent <= sent + 1;
          expected_res.push_back(allocate_or_free(r));
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
          end
        end
      end
    end
  end

  // Monitor: compare each strobed result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result status=%0d id=%0d",
                                       res_o.status, res_o.granted_id);
      end else begin
        res_t e;
        e = expected_res.pop_front();
        if (res_o.status !== e.status || res_o.granted_id !== e.granted_id) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected status=%0d id=%0d, got status=%0d id=%0d",
                     e.status, e.granted_id, res_o.status, res_o.granted_id);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start_i && !busy_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    mismatches = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    wait (rst_ni && fill_done);
    wait ((pending_reqs.size() == 0 && !start_i) || idle_cycles >= WatchdogLimit);
    while (expected_res.size() > 0 && idle_cycles < WatchdogLimit) @(posedge clk_i);
    if (idle_cycles >= WatchdogLimit) timed_out = 1'b1;
    repeat (200) @(posedge clk_i);
    if (timed_out) begin
      $display("Test completed with failures");
    end else if (mismatches == 0 && expected_res.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
